// ===== rtl/mhft_pkg.sv =====
// shared types and constants of the mail header field tokenizer
package mhft_pkg;

  localparam int unsigned FIELD_BITS = 32;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_EOH   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [FIELD_BITS-1:0] name_offset;
    logic [FIELD_BITS-1:0] name_length;
    logic [FIELD_BITS-1:0] value_offset;
    logic [FIELD_BITS-1:0] value_length;
  } result_t;

endpackage

// ===== rtl/mhft_intf.sv =====
// valid/ready channel interfaces for message bytes and parse results
interface mhft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface mhft_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] name_offset;
  logic [31:0] name_length;
  logic [31:0] value_offset;
  logic [31:0] value_length;

  modport source (output valid, output result_kind, output name_offset,
                  output name_length, output value_offset, output value_length,
                  input ready);
  modport sink   (input valid, input result_kind, input name_offset,
                  input name_length, input value_offset, input value_length,
                  output ready);
endinterface

// ===== rtl/mail_header_field_tokenizer.sv =====
// top level of the mail header field tokenizer
//
//  channel  dir  word contents
//  in_i     in   data_byte, message_end
//  out_o    out  result_kind, name_offset, name_length, value_offset, value_length
//
// one byte word accepted per cycle unless the input stalls; each byte passes through the
// input register, parse logic and result buffer before its result is offered on out_o
// input stalls only while two results wait in the buffer and out_o is not ready
// reset clears offset counter and parse state to the start of a message
module mail_header_field_tokenizer
  import mhft_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mhft_byte_if.sink      in_i,
  mhft_result_if.source  out_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       advance;
  logic       pop;
  logic       buf_full;
  logic       buf_valid;
  logic       res_valid;
  result_t    res;
  result_t    head;

  assign pop        = buf_valid && out_o.ready;
  assign advance    = s1_valid_q && (!buf_full || pop);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_end_q  <= in_i.message_end;
    end
  end

  mhft_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (s1_byte_q),
    .message_end_i(s1_end_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mhft_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (advance && res_valid),
    .wr_data_i(res),
    .rd_i     (pop),
    .valid_o  (buf_valid),
    .full_o   (buf_full),
    .rd_data_o(head)
  );

  assign out_o.valid        = buf_valid;
  assign out_o.result_kind  = head.kind;
  assign out_o.name_offset  = head.name_offset;
  assign out_o.name_length  = head.name_length;
  assign out_o.value_offset = head.value_offset;
  assign out_o.value_length = head.value_length;

endmodule

// ===== rtl/mhft_parser.sv =====
// header parse state machine, one registered byte per step
module mhft_parser
  import mhft_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       message_end_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_NAME_START = 3'd0,
    PH_NAME       = 3'd1,
    PH_BLANKS     = 3'd2,
    PH_VALUE      = 3'd3,
    PH_LF         = 3'd4,
    PH_AFTER_EOL  = 3'd5,
    PH_END_LF     = 3'd6,
    PH_DONE       = 3'd7
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] name_start_q, name_start_d;
  logic [OFFSET_BITS-1:0] name_count_q, name_count_d;
  logic [OFFSET_BITS-1:0] value_start_q, value_start_d;
  logic [OFFSET_BITS-1:0] value_end_q, value_end_d;

  logic    is_blank;
  result_t field_res;

  assign is_blank = (data_byte_i == CH_SP) || (data_byte_i == CH_TAB);

  always_comb begin
    field_res.kind         = KIND_FIELD;
    field_res.name_offset  = FIELD_BITS'(name_start_q);
    field_res.name_length  = FIELD_BITS'(name_count_q);
    field_res.value_offset = FIELD_BITS'(value_start_q);
    field_res.value_length = FIELD_BITS'(value_end_q - value_start_q);
  end

  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q + OFFSET_BITS'(1);
    name_start_d  = name_start_q;
    name_count_d  = name_count_q;
    value_start_d = value_start_q;
    value_end_d   = value_end_q;
    res_valid_o   = 1'b0;
    res_o         = '0;

    unique case (phase_q)
      PH_NAME_START: begin
        if (data_byte_i == CH_CR) begin
          phase_d = PH_END_LF;
        end else begin
          name_start_d = pos_q;
          name_count_d = OFFSET_BITS'(1);
          phase_d      = PH_NAME;
        end
      end
      PH_NAME: begin
        if (data_byte_i == CH_COLON) begin
          phase_d = PH_BLANKS;
        end else begin
          name_count_d = name_count_q + OFFSET_BITS'(1);
        end
      end
      PH_BLANKS: begin
        if (!is_blank) begin
          value_start_d = pos_q;
          if (data_byte_i == CH_CR) begin
            value_end_d = pos_q;
            phase_d     = PH_LF;
          end else begin
            phase_d = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (data_byte_i == CH_CR) begin
          value_end_d = pos_q;
          phase_d     = PH_LF;
        end
      end
      PH_LF: begin
        if (data_byte_i == CH_LF) begin
          phase_d = PH_AFTER_EOL;
        end else if (data_byte_i == CH_CR) begin
          value_end_d = pos_q;
        end else begin
          phase_d = PH_VALUE;
        end
      end
      PH_AFTER_EOL: begin
        if (is_blank) begin
          phase_d = PH_VALUE;
        end else begin
          res_valid_o = 1'b1;
          res_o       = field_res;
          if (data_byte_i == CH_CR) begin
            phase_d = PH_END_LF;
          end else begin
            name_start_d = pos_q;
            name_count_d = OFFSET_BITS'(1);
            phase_d      = PH_NAME;
          end
        end
      end
      PH_END_LF: begin
        if (data_byte_i == CH_LF) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_EOH;
          phase_d     = PH_DONE;
        end else if (data_byte_i == CH_CR) begin
          phase_d = PH_END_LF;
        end else begin
          name_start_d = pos_q;
          name_count_d = OFFSET_BITS'(1);
          phase_d      = PH_NAME;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
    endcase

    if (message_end_i) begin
      if (phase_d == PH_NAME || phase_d == PH_BLANKS ||
          phase_d == PH_VALUE || phase_d == PH_LF) begin
        res_valid_o       = 1'b1;
        res_o             = '0;
        res_o.kind        = KIND_ERROR;
        res_o.name_offset = FIELD_BITS'(name_start_d);
        res_o.name_length = FIELD_BITS'(name_count_d);
      end else if (phase_d == PH_AFTER_EOL) begin
        res_valid_o = 1'b1;
        res_o       = field_res;
      end
      phase_d       = PH_NAME_START;
      pos_d         = '0;
      name_start_d  = '0;
      name_count_d  = '0;
      value_start_d = '0;
      value_end_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_NAME_START;
      pos_q         <= '0;
      name_start_q  <= '0;
      name_count_q  <= '0;
      value_start_q <= '0;
      value_end_q   <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      pos_q         <= pos_d;
      name_start_q  <= name_start_d;
      name_count_q  <= name_count_d;
      value_start_q <= value_start_d;
      value_end_q   <= value_end_d;
    end
  end

endmodule

// ===== rtl/mhft_out_buf.sv =====
// two-entry result buffer between the parser and the output channel
module mhft_out_buf
  import mhft_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wr_data_i,
  input  logic    rd_i,
  output logic    valid_o,
  output logic    full_o,
  output result_t rd_data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o   = (count_q != 2'd0);
  assign full_o    = (count_q == 2'd2);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the mail header field tokenizer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhft_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 300;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [2:0] {
    SCAN_LINE_START,
    SCAN_NAME,
    SCAN_BLANKS,
    SCAN_VALUE,
    SCAN_CR_SEEN,
    SCAN_LINE_END,
    SCAN_BLANK_CR,
    SCAN_BODY
  } scan_e;

  logic clk;
  logic rst_n;

  mhft_byte_if   byte_ch ();
  mhft_result_if result_ch ();

  mail_header_field_tokenizer #(
    .OFFSET_BITS(32)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (result_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // header field predictor
  logic [31:0] byte_pos;
  logic [31:0] name_start;
  logic [31:0] name_count;
  logic [31:0] value_start;
  logic [31:0] value_end;
  scan_e       scan;
  result_t     expected_results[$];

  logic [7:0]  message_bytes[$];
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_request = 1'b0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  function automatic void clear_parser();
    byte_pos    = '0;
    scan        = SCAN_LINE_START;
    name_start  = '0;
    name_count  = '0;
    value_start = '0;
    value_end   = '0;
  endfunction

  function automatic void start_line(input logic [7:0] b, input logic [31:0] at);
    if (b == CH_CR) begin
      scan = SCAN_BLANK_CR;
    end else begin
      name_start = at;
      name_count = 32'd1;
      scan       = SCAN_NAME;
    end
  endfunction

  function automatic result_t field_result();
    result_t r;
    r              = '0;
    r.kind         = KIND_FIELD;
    r.name_offset  = name_start;
    r.name_length  = name_count;
    r.value_offset = value_start;
    r.value_length = value_end - value_start;
    return r;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic        emit;
    logic [31:0] at;
    r    = '0;
    emit = 1'b0;
    at   = byte_pos;
    case (scan)
      SCAN_LINE_START: start_line(b, at);
      SCAN_NAME: begin
        if (b == CH_COLON) scan = SCAN_BLANKS;
        else name_count = name_count + 32'd1;
      end
      SCAN_BLANKS: begin
        if (b != CH_SP && b != CH_TAB) begin
          value_start = at;
          if (b == CH_CR) begin
            value_end = at;
            scan      = SCAN_CR_SEEN;
          end else begin
            scan = SCAN_VALUE;
          end
        end
      end
      SCAN_VALUE: begin
        if (b == CH_CR) begin
          value_end = at;
          scan      = SCAN_CR_SEEN;
        end
      end
      SCAN_CR_SEEN: begin
        if (b == CH_LF) scan = SCAN_LINE_END;
        else if (b == CH_CR) value_end = at;
        else scan = SCAN_VALUE;
      end
      SCAN_LINE_END: begin
        if (b == CH_SP || b == CH_TAB) begin
          scan = SCAN_VALUE;
        end else begin
          r    = field_result();
          emit = 1'b1;
          start_line(b, at);
        end
      end
      SCAN_BLANK_CR: begin
        if (b == CH_LF) begin
          r      = '0;
          r.kind = KIND_EOH;
          emit   = 1'b1;
          scan   = SCAN_BODY;
        end else begin
          start_line(b, at);
        end
      end
      default: scan = SCAN_BODY;
    endcase
    byte_pos = at + 32'd1;
    if (last) begin
      // message cut inside a field overrides any field result of this word
      if (scan inside {SCAN_NAME, SCAN_BLANKS, SCAN_VALUE, SCAN_CR_SEEN}) begin
        r             = '0;
        r.kind        = KIND_ERROR;
        r.name_offset = name_start;
        r.name_length = name_count;
        emit          = 1'b1;
      end else if (scan == SCAN_LINE_END) begin
        r    = field_result();
        emit = 1'b1;
      end
      clear_parser();
    end
    if (emit) expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.data_byte, byte_ch.message_end);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result_kind: expected no word, got %0d", result_ch.result_kind);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_ch.result_kind));
          check_field("name_offset", want.name_offset, result_ch.name_offset);
          check_field("name_length", want.name_length, result_ch.name_length);
          check_field("value_offset", want.value_offset, result_ch.value_offset);
          check_field("value_length", want.value_length, result_ch.value_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result receiver
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = pick_gap(sink_gaps);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(src_gaps);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.message_end <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  task automatic send_message(input bit mark_end);
    for (int i = 0; i < message_bytes.size(); i++) begin
      send_byte(message_bytes[i], mark_end && (i == message_bytes.size() - 1));
    end
    message_bytes.delete();
  endtask

  task automatic wait_results_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    message_bytes.insert(message_bytes.size(), b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic logic [7:0] random_text_byte(input bit for_name);
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (for_name && (b == CH_COLON || b == CH_CR)) b = "x";
    end else if (for_name) begin
      b = 8'($urandom_range(33, 126));
      if (b == CH_COLON) b = "-";
    end else begin
      b = 8'($urandom_range(32, 126));
    end
    return b;
  endfunction

  // extreme bytes, folds, bare and doubled cr, colon-led name, stray cr, body
  task automatic test_folded_and_odd_lines();
    add_byte(8'h00);
    add_text(": ");
    add_byte(CH_TAB);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_text("q");
    add_byte(CH_CR);
    add_crlf();
    add_text(" v");
    add_crlf();
    add_text(":x:");
    add_crlf();
    add_byte(CH_CR);
    add_text("z:");
    add_crlf();
    add_crlf();
    add_text("j");
    send_message(1'b1);
  endtask

  task automatic test_message_end_cases();
    add_text("n");
    send_message(1'b1);
    add_text("a:");
    add_byte(CH_TAB);
    send_message(1'b1);
    add_text("a: b");
    add_byte(CH_CR);
    send_message(1'b1);
    add_text("a:b");
    add_crlf();
    send_message(1'b1);
    add_byte(CH_CR);
    send_message(1'b1);
    add_text("a:b");
    add_crlf();
    add_byte(CH_CR);
    send_message(1'b1);
    add_text("a:b");
    add_crlf();
    add_text("c");
    send_message(1'b1);
    add_crlf();
    add_text("xyz");
    send_message(1'b1);
  endtask

  task automatic test_result_backpressure();
    src_gaps     = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 1'b1;
    repeat (24) begin
      add_text("k:v");
      add_crlf();
    end
    add_crlf();
    send_message(1'b1);
    wait_results_drained();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    add_text("Subject: hi");
    add_crlf();
    add_text("To: x");
    add_crlf();
    send_message(1'b0);
    wait_results_drained();
    add_crlf();
    send_message(1'b1);
  endtask

  task automatic test_random_messages();
    int header_bytes;
    int nseg;
    int ending;
    int cut;
    header_bytes = 0;
    while (header_bytes < RANDOM_BYTES) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(1, 5)) begin
          repeat ($urandom_range(1, 8)) add_byte(random_text_byte(1'b1));
          add_byte(CH_COLON);
          repeat ($urandom_range(0, 3))
            add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
          nseg = $urandom_range(1, 3);
          for (int s = 0; s < nseg; s++) begin
            if (s > 0) begin
              add_crlf();
              add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
            end
            repeat ($urandom_range(0, 10)) add_byte(random_text_byte(1'b0));
          end
          add_crlf();
        end
        ending = $urandom_range(0, 99);
        if (ending < 70) begin
          add_crlf();
          header_bytes += message_bytes.size();
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        end else begin
          if (ending >= 85) begin
            cut           = $urandom_range(1, message_bytes.size());
            message_bytes = message_bytes[0:cut-1];
          end
          header_bytes += message_bytes.size();
        end
      end else begin
        repeat ($urandom_range(1, 16)) begin
          case ($urandom_range(0, 7))
            0:       add_byte(CH_COLON);
            1:       add_byte(CH_CR);
            2:       add_byte(CH_LF);
            3:       add_byte(CH_SP);
            4:       add_byte(CH_TAB);
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        header_bytes += message_bytes.size();
      end
      send_message(1'b1);
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.message_end <= 1'b0;
    result_ch.ready     <= 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_folded_and_odd_lines();
    test_message_end_cases();
    test_result_backpressure();
    test_sender_pause();
    test_random_messages();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
